// ===== rtl/core/bslp_pkg.sv =====
// ----------------------------------------------------------------------------
// bslp_pkg
// shared types and constants of the button short/long press detector
// ----------------------------------------------------------------------------
`default_nettype none

package bslp_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int FUNC_W     = 2;
    localparam int CHAN_W     = 3;
    localparam int LEVELS_W   = 8;
    localparam int CODE_W     = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CU_W       = 4;
    localparam int ACT_W      = 8;
    localparam int THR_REG_W  = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK         = 2'd0,
        FUNC_READ         = 2'd1,
        FUNC_READ_EDGE    = 2'd2,
        FUNC_READ_RELEASE = 2'd3
    } func_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_RELEASED = 2'd0,
        CODE_SHORT    = 2'd1,
        CODE_LONG     = 2'd2,
        CODE_FAULT    = 2'd3
    } code_t;

    typedef enum logic [1:0] {
        REG_CHANNELS_USED = 2'd0,
        REG_ACTIVE_LEVELS = 2'd1,
        REG_SHORT_COUNT   = 2'd2,
        REG_LONG_COUNT    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic tick;
        logic clr_edge;
        logic clr_release;
        logic clear;
    } lane_ctrl_t;

    typedef struct packed {
        code_t mode;
        code_t edge_evt;
        code_t rel_evt;
    } lane_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bslp_lane.sv =====
// ----------------------------------------------------------------------------
// bslp_lane
// per-channel press qualifier: hold counter, press mode and latched events
// ----------------------------------------------------------------------------
`default_nettype none

module bslp_lane #(
    parameter int COUNT_WIDTH = bslp_pkg::COUNT_WIDTH_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  bslp_pkg::lane_ctrl_t    ctrl,
    input  wire                     level,
    input  wire                     active,
    input  wire  [COUNT_WIDTH-1:0]  short_thr,
    input  wire  [COUNT_WIDTH-1:0]  long_thr,
    input  wire                     long_off,
    output bslp_pkg::lane_status_t  status
);

    bslp_pkg::code_t        mode_reg, mode_next;
    bslp_pkg::code_t        edge_reg, edge_next;
    bslp_pkg::code_t        rel_reg, rel_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   held;

    assign held    = (level == active);
    assign cnt_inc = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;

    always_comb begin
        mode_next = mode_reg;
        edge_next = edge_reg;
        rel_next  = rel_reg;
        cnt_next  = cnt_reg;
        if (ctrl.clear) begin
            mode_next = bslp_pkg::CODE_RELEASED;
            edge_next = bslp_pkg::CODE_RELEASED;
            rel_next  = bslp_pkg::CODE_RELEASED;
            cnt_next  = '0;
        end else begin
            if (ctrl.tick) begin
                case (mode_reg)
                    bslp_pkg::CODE_RELEASED: begin
                        if (held) begin
                            cnt_next = cnt_inc;
                            if (cnt_inc >= short_thr) begin
                                mode_next = bslp_pkg::CODE_SHORT;
                            end
                        end else begin
                            cnt_next = '0;
                        end
                    end
                    bslp_pkg::CODE_SHORT: begin
                        if (held) begin
                            cnt_next = cnt_inc;
                            if (!long_off && cnt_inc >= long_thr) begin
                                mode_next = bslp_pkg::CODE_LONG;
                                edge_next = bslp_pkg::CODE_LONG;
                                cnt_next  = '0;
                            end
                        end else begin
                            mode_next = bslp_pkg::CODE_RELEASED;
                            cnt_next  = '0;
                            rel_next  = bslp_pkg::CODE_SHORT;
                            edge_next = bslp_pkg::CODE_SHORT;
                        end
                    end
                    default: begin
                        if (!held) begin
                            mode_next = bslp_pkg::CODE_RELEASED;
                            cnt_next  = '0;
                            rel_next  = bslp_pkg::CODE_LONG;
                        end
                    end
                endcase
            end
            if (ctrl.clr_edge) begin
                edge_next = bslp_pkg::CODE_RELEASED;
            end
            if (ctrl.clr_release) begin
                rel_next = bslp_pkg::CODE_RELEASED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= bslp_pkg::CODE_RELEASED;
            edge_reg <= bslp_pkg::CODE_RELEASED;
            rel_reg  <= bslp_pkg::CODE_RELEASED;
            cnt_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            edge_reg <= edge_next;
            rel_reg  <= rel_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign status.mode     = mode_reg;
    assign status.edge_evt = edge_reg;
    assign status.rel_evt  = rel_reg;

    // press mode never holds the fault code
    a_mode_not_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != bslp_pkg::CODE_FAULT)
        else $error("lane press mode holds fault code");

    // a long edge event appears together with the long press mode
    a_long_edge_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (edge_reg == bslp_pkg::CODE_LONG && $past(edge_reg) != bslp_pkg::CODE_LONG)
        |-> mode_reg == bslp_pkg::CODE_LONG)
        else $error("long edge event without long press");

endmodule

`default_nettype wire

// ===== rtl/core/bslp_merge.sv =====
// ----------------------------------------------------------------------------
// bslp_merge
// selects the addressed lane and resolves the read code
// ----------------------------------------------------------------------------
`default_nettype none

module bslp_merge #(
    parameter int CHANNELS = bslp_pkg::CHANNELS_DEF
) (
    input  bslp_pkg::lane_status_t           status [CHANNELS],
    input  wire  [bslp_pkg::CHAN_W-1:0]      channel,
    input  bslp_pkg::func_t                  func,
    input  wire                              ch_ok,
    output bslp_pkg::code_t                  code
);

    bslp_pkg::lane_status_t sel;

    always_comb begin
        sel = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (32'(channel) == i) begin
                sel = status[i];
            end
        end
        case (func)
            bslp_pkg::FUNC_READ:         code = sel.mode;
            bslp_pkg::FUNC_READ_EDGE:    code = sel.edge_evt;
            bslp_pkg::FUNC_READ_RELEASE: code = sel.rel_evt;
            default:                     code = sel.mode;
        endcase
        if (!ch_ok) begin
            code = bslp_pkg::CODE_FAULT;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bslp_out_buf.sv =====
// ----------------------------------------------------------------------------
// bslp_out_buf
// output register with one skid entry for the result stream
// ----------------------------------------------------------------------------
`default_nettype none

module bslp_out_buf (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    input  bslp_pkg::code_t                  in_code,
    output logic                             in_ready,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [bslp_pkg::M_TDATA_W-1:0]   m_tdata    // [1:0] state_code
);

    logic            out_valid_reg, out_valid_next;
    logic            skid_valid_reg, skid_valid_next;
    bslp_pkg::code_t out_code_reg, out_code_next;
    bslp_pkg::code_t skid_code_reg, skid_code_next;
    logic            out_fire;

    assign out_fire = out_valid_reg && m_tready;
    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_code_next   = out_code_reg;
        skid_code_next  = skid_code_reg;
        if (out_fire) begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_valid_next  = 1'b1;
                out_code_next   = skid_code_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_next = 1'b1;
                out_code_next  = in_code;
            end else begin
                skid_valid_next = 1'b1;
                skid_code_next  = in_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_code_reg  <= out_code_next;
        skid_code_reg <= skid_code_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bslp_pkg::M_TDATA_W'(out_code_reg);

endmodule

`default_nettype wire

// ===== rtl/core/button_short_long_press_detector.sv =====
// ----------------------------------------------------------------------------
// button_short_long_press_detector
// debounced short/long press qualifier for up to CHANNELS button levels
// ----------------------------------------------------------------------------
// A transaction is taken every clock cycle while s_tready is high. A tick
// updates the enabled lanes in parallel in the cycle it is accepted and
// gives no result; a read gives one result on m_tdata through an output
// register with one skid entry, so s_tready drops only when both are full.
// User sets thresholds, channel count via APB port while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module button_short_long_press_detector #(
    parameter int CHANNELS    = bslp_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = bslp_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // [1:0] func, [4:2] channel, [12:5] levels
    input  wire  [bslp_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // [1:0] state_code
    output logic [bslp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [bslp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire  [bslp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bslp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int THR_W = (COUNT_WIDTH < bslp_pkg::THR_REG_W) ?
                           COUNT_WIDTH : bslp_pkg::THR_REG_W;

    logic [bslp_pkg::CU_W-1:0]  cu_reg;
    logic [bslp_pkg::ACT_W-1:0] act_reg;
    logic [THR_W-1:0]           short_reg;
    logic [THR_W-1:0]           long_reg;

    bslp_pkg::cfg_reg_t         cfg_idx;
    logic                       cfg_wr;

    bslp_pkg::func_t                func;
    logic [bslp_pkg::CHAN_W-1:0]    channel;
    logic [bslp_pkg::LEVELS_W-1:0]  levels;
    logic                           s_fire;
    logic                           ch_ok;

    logic [COUNT_WIDTH-1:0] short_thr;
    logic [COUNT_WIDTH-1:0] long_raw;
    logic [COUNT_WIDTH-1:0] long_thr;
    logic                   long_off;

    bslp_pkg::lane_ctrl_t   lane_ctrl   [CHANNELS];
    bslp_pkg::lane_status_t lane_status [CHANNELS];
    bslp_pkg::code_t        rd_code;
    logic                   buf_ready;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = bslp_pkg::cfg_reg_t'(paddr[bslp_pkg::CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cu_reg    <= '0;
            act_reg   <= '0;
            short_reg <= THR_W'(1);
            long_reg  <= '1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bslp_pkg::REG_CHANNELS_USED: cu_reg    <= pwdata[bslp_pkg::CU_W-1:0];
                bslp_pkg::REG_ACTIVE_LEVELS: act_reg   <= pwdata[bslp_pkg::ACT_W-1:0];
                bslp_pkg::REG_SHORT_COUNT:   short_reg <= pwdata[THR_W-1:0];
                bslp_pkg::REG_LONG_COUNT:    long_reg  <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bslp_pkg::REG_CHANNELS_USED: prdata = bslp_pkg::CFG_DATA_W'(cu_reg);
            bslp_pkg::REG_ACTIVE_LEVELS: prdata = bslp_pkg::CFG_DATA_W'(act_reg);
            bslp_pkg::REG_SHORT_COUNT:   prdata = bslp_pkg::CFG_DATA_W'(short_reg);
            bslp_pkg::REG_LONG_COUNT:    prdata = bslp_pkg::CFG_DATA_W'(long_reg);
            default:                     prdata = '0;
        endcase
    end

    // effective thresholds, shared by all lanes
    assign short_thr = (short_reg == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(short_reg);
    assign long_raw  = COUNT_WIDTH'(long_reg);
    assign long_thr  = (long_raw < short_thr) ? short_thr : long_raw;
    assign long_off  = &long_thr;

    // input transaction
    assign func    = bslp_pkg::func_t'(s_tdata[1:0]);
    assign channel = s_tdata[4:2];
    assign levels  = s_tdata[12:5];
    assign s_tready = buf_ready;
    assign s_fire   = s_tvalid && s_tready;
    assign ch_ok    = ({1'b0, channel} < cu_reg) && (32'(channel) < CHANNELS);

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        logic lvl;
        logic act;
        logic hit;

        if (i < bslp_pkg::LEVELS_W) begin : g_bit
            assign lvl = levels[i];
            assign act = act_reg[i];
        end else begin : g_none
            assign lvl = 1'b0;
            assign act = 1'b0;
        end

        assign hit = ch_ok && (32'(channel) == i);

        assign lane_ctrl[i].tick = s_fire && (func == bslp_pkg::FUNC_TICK) &&
                                   (i < int'(cu_reg));
        assign lane_ctrl[i].clr_edge = s_fire && hit &&
                                       ((func == bslp_pkg::FUNC_READ_EDGE) ||
                                        (func == bslp_pkg::FUNC_READ_RELEASE));
        assign lane_ctrl[i].clr_release = s_fire && hit &&
                                          (func == bslp_pkg::FUNC_READ_RELEASE);
        assign lane_ctrl[i].clear = cfg_wr && (cfg_idx == bslp_pkg::REG_CHANNELS_USED) &&
                                    (i >= int'(pwdata[bslp_pkg::CU_W-1:0]));

        bslp_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl[i]),
            .level     (lvl),
            .active    (act),
            .short_thr (short_thr),
            .long_thr  (long_thr),
            .long_off  (long_off),
            .status    (lane_status[i])
        );
    end

    bslp_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .status  (lane_status),
        .channel (channel),
        .func    (func),
        .ch_ok   (ch_ok),
        .code    (rd_code)
    );

    bslp_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_fire && (func != bslp_pkg::FUNC_TICK)),
        .in_code  (rd_code),
        .in_ready (buf_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a read always shows a result in the next cycle
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && func != bslp_pkg::FUNC_TICK) |=> m_tvalid)
        else $error("read transaction gave no result");

    // a tick into an empty output stage leaves it empty
    a_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && func == bslp_pkg::FUNC_TICK && !m_tvalid) |=> !m_tvalid)
        else $error("tick transaction produced a result");

    // input stalls only while a result waits on the output
    a_stall_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a fault code is only returned for a channel that is out of range
    a_fault_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && func != bslp_pkg::FUNC_TICK && ch_ok && !m_tvalid)
        |=> m_tdata[1:0] != bslp_pkg::CODE_FAULT)
        else $error("fault returned for enabled channel");

endmodule

`default_nettype wire
